// ===== design/xtea_block_cipher_top_macros.svh =====
// Assertion macros for the XTEA block cipher.
// Used by xtea_block_cipher_top; no other dependencies.
// Macros are empty when SYNTHESIS is defined.
`ifndef XTEA_BLOCK_CIPHER_TOP_MACROS_SVH
`define XTEA_BLOCK_CIPHER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define XTEA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define XTEA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define XTEA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define XTEA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/xtea_pkg.sv =====
// Constants and helper functions for the XTEA block cipher pipeline.
// No dependencies.
package xtea_pkg;

    localparam int ROUNDS     = 32;
    localparam int NUM_STAGES = 2 * ROUNDS;
    localparam int CFG_AW     = 3;

    localparam logic [31:0] DELTA = 32'h9E3779B9;

    localparam logic [31:0] KEY0_RST = 32'h6C0A5452;
    localparam logic [31:0] KEY1_RST = 32'h03827D0F;
    localparam logic [31:0] KEY2_RST = 32'h3A170B92;
    localparam logic [31:0] KEY3_RST = 32'h16DB7FC2;

    localparam logic [CFG_AW-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_AW-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MODE = 3'd4;

    function automatic logic [31:0] mix(input logic [31:0] v);
        mix = ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // running sum used by half-round h when enciphering
    function automatic logic [31:0] enc_sum(input int h);
        logic [31:0] n;
        n = 32'((h + 1) >> 1);
        enc_sum = n * DELTA;
    endfunction

    // running sum used by half-round h when deciphering
    function automatic logic [31:0] dec_sum(input int h);
        logic [31:0] n;
        n = 32'(ROUNDS - ((h + 1) >> 1));
        dec_sum = n * DELTA;
    endfunction

    function automatic logic [1:0] key_sel(input logic [31:0] sum, input logic use_hi);
        key_sel = use_hi ? sum[12:11] : sum[1:0];
    endfunction

endpackage

// ===== design/xtea_block_cipher_top.sv =====
// Throughput: one block per cycle while the skid register is empty; one register stage per XTEA half-round.
// Output skid register absorbs one block when the output stalls; input stalls while it is full.
// Reset (i_rst_n, synchronous, active low) clears valids, restores default
// key and selects encipher.
// XTEA pipeline top level; depends on xtea_pkg and the assertion macros header.
`include "xtea_block_cipher_top_macros.svh"

module xtea_block_cipher_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [xtea_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [31:0]                 i_cfg_wdata,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [63:0]                 i_s_tdata,   // [31:0] block_low, [63:32] block_high
    // output stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [63:0]                 o_m_tdata    // [31:0] result_low, [63:32] result_high
);

    localparam int N = xtea_pkg::NUM_STAGES;

    logic [31:0] r_key [4];
    logic        r_dec;

    logic [N:0]  r_v;
    logic [31:0] r_a [N+1];
    logic [31:0] r_b [N+1];
    logic [31:0] n_a [N];
    logic [31:0] n_b [N];

    logic        r_skid_valid;
    logic [63:0] r_skid_data;
    logic        en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= xtea_pkg::KEY0_RST;
            r_key[1] <= xtea_pkg::KEY1_RST;
            r_key[2] <= xtea_pkg::KEY2_RST;
            r_key[3] <= xtea_pkg::KEY3_RST;
            r_dec    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                xtea_pkg::REG_KEY0: r_key[0] <= i_cfg_wdata;
                xtea_pkg::REG_KEY1: r_key[1] <= i_cfg_wdata;
                xtea_pkg::REG_KEY2: r_key[2] <= i_cfg_wdata;
                xtea_pkg::REG_KEY3: r_key[3] <= i_cfg_wdata;
                xtea_pkg::REG_MODE: r_dec    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign en         = !r_skid_valid;
    assign o_s_tready = en;

    // half-round stages
    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic [31:0] ENC_SUM = xtea_pkg::enc_sum(g);
        localparam logic [31:0] DEC_SUM = xtea_pkg::dec_sum(g);
        localparam logic        EVEN    = ((g & 1) == 0);
        localparam logic [1:0]  ENC_KS  = xtea_pkg::key_sel(ENC_SUM, !EVEN);
        localparam logic [1:0]  DEC_KS  = xtea_pkg::key_sel(DEC_SUM, EVEN);

        logic        upd_a;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] sk;
        logic [31:0] t;
        logic [31:0] res;

        always_comb begin
            upd_a = r_dec ? !EVEN : EVEN;
            src   = upd_a ? r_b[g] : r_a[g];
            dst   = upd_a ? r_a[g] : r_b[g];
            sk    = r_dec ? (DEC_SUM + r_key[DEC_KS]) : (ENC_SUM + r_key[ENC_KS]);
            t     = xtea_pkg::mix(src) ^ sk;
            res   = r_dec ? (dst - t) : (dst + t);
            n_a[g] = upd_a ? res : r_a[g];
            n_b[g] = upd_a ? r_b[g] : res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[N-1:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0] <= i_s_tdata[31:0];
            r_b[0] <= i_s_tdata[63:32];
            for (int i = 0; i < N; i++) begin
                r_a[i+1] <= n_a[i];
                r_b[i+1] <= n_b[i];
            end
        end
    end

    // output skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_v[N] && !i_m_tready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_data <= {r_b[N], r_a[N]};
        end
    end

    assign o_m_tvalid = r_skid_valid | r_v[N];
    assign o_m_tdata  = r_skid_valid ? r_skid_data : {r_b[N], r_a[N]};

    `XTEA_ASSERT_IMP(a_skid_from_stall, i_clk, i_rst_n, $rose(r_skid_valid),
        $past(r_v[N] && !i_m_tready))
    `XTEA_ASSERT_NXT(a_frozen_last, i_clk, i_rst_n, r_skid_valid,
        r_v[N] == $past(r_v[N]))
    `XTEA_ASSERT_NXT(a_skid_drain, i_clk, i_rst_n, r_skid_valid && i_m_tready,
        !r_skid_valid)

endmodule

// ===== test/xtea_block_cipher_top_tb.sv =====
// Self-checking testbench for xtea_block_cipher_top: XTEA encipher/decipher under
// changing keys and modes, with random source gaps and sink stalls.
// Depends on xtea_pkg and the xtea_block_cipher_top RTL.
`timescale 1ns / 100ps

module xtea_block_cipher_top_tb;

    localparam int PIPE_LAT    = 2 * xtea_pkg::ROUNDS + 1;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_ITEMS  = 1550;

    localparam logic [xtea_pkg::CFG_AW-1:0] REG_NONE_FIRST = xtea_pkg::REG_MODE + 1'b1;
    localparam logic [xtea_pkg::CFG_AW-1:0] REG_NONE_LAST  = '1;

    typedef struct packed {
        logic [31:0] high;
        logic [31:0] low;
    } t_word_pair;

    typedef enum logic [1:0] {CMD_BLOCK, CMD_CFG, CMD_DRAIN} t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                   kind;
        logic [xtea_pkg::CFG_AW-1:0] addr;
        logic [31:0]                 wdata;
        t_word_pair                  blk;
    } t_cmd;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [xtea_pkg::CFG_AW-1:0] cfg_addr  = '0;
    logic [31:0]                 cfg_wdata = '0;
    logic                        s_tvalid  = 1'b0;
    logic [63:0]                 s_tdata   = '0;
    logic                        m_tready  = 1'b0;
    logic                        s_tready;
    logic                        m_tvalid;
    logic [63:0]                 m_tdata;

    t_cmd       cmd_q[$];
    t_word_pair cipher_exp_q[$];

    // shadow copy of the block's configuration
    logic [3:0][31:0] key_shadow;
    logic             decrypt_shadow;

    int n_sent;
    int n_recv = 0;
    int n_err = 0;
    int cycle_cnt = 0;
    int src_gap, src_run, sink_gap, sink_run;

    logic       next_valid, next_we;
    t_cmd       head;
    t_word_pair want, got;

    xtea_block_cipher_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] round_f(logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function automatic t_word_pair xtea_crypt(t_word_pair blk, logic [3:0][31:0] key,
                                              logic dec);
        logic [31:0] a, b, sum;
        t_word_pair  res;
        a = blk.low;
        b = blk.high;
        if (!dec) begin
            sum = '0;
            for (int r = 0; r < xtea_pkg::ROUNDS; r++) begin
                a = a + (round_f(b) ^ (sum + key[sum[1:0]]));
                sum = sum + xtea_pkg::DELTA;
                b = b + (round_f(a) ^ (sum + key[sum[12:11]]));
            end
        end else begin
            sum = xtea_pkg::DELTA * 32'(xtea_pkg::ROUNDS);
            for (int r = 0; r < xtea_pkg::ROUNDS; r++) begin
                b = b - (round_f(a) ^ (sum + key[sum[12:11]]));
                sum = sum - xtea_pkg::DELTA;
                a = a - (round_f(b) ^ (sum + key[sum[1:0]]));
            end
        end
        res.low  = a;
        res.high = b;
        return res;
    endfunction

    function automatic void apply_cfg(logic [xtea_pkg::CFG_AW-1:0] addr, logic [31:0] data);
        if (addr <= xtea_pkg::REG_KEY3)
            key_shadow[addr[1:0]] = data;
        else if (addr == xtea_pkg::REG_MODE)
            decrypt_shadow = data[0];
    endfunction

    // mostly short gaps, a few long ones, occasional runs with none
    function automatic int pick_gap(inout int run);
        int r;
        if (run > 0) begin
            run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            run = $urandom_range(20, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        if (r < 24) return 32'(1) << $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic void add_block(logic [31:0] lo, logic [31:0] hi);
        t_cmd c;
        c = '0;
        c.kind     = CMD_BLOCK;
        c.blk.low  = lo;
        c.blk.high = hi;
        cmd_q.push_back(c);
    endfunction

    function automatic void add_cfg(logic [xtea_pkg::CFG_AW-1:0] addr, logic [31:0] data);
        t_cmd c;
        c = '0;
        c.kind  = CMD_CFG;
        c.addr  = addr;
        c.wdata = data;
        cmd_q.push_back(c);
    endfunction

    function automatic void add_drain();
        t_cmd c;
        c = '0;
        c.kind = CMD_DRAIN;
        cmd_q.push_back(c);
    endfunction

    function automatic void add_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                                    logic [31:0] k3);
        add_cfg(xtea_pkg::REG_KEY0, k0);
        add_cfg(xtea_pkg::REG_KEY1, k1);
        add_cfg(xtea_pkg::REG_KEY2, k2);
        add_cfg(xtea_pkg::REG_KEY3, k3);
    endfunction

    // source side: blocks, config writes (only when drained), pauses
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            cfg_we    <= 1'b0;
            cfg_addr  <= '0;
            cfg_wdata <= '0;
            key_shadow     = {xtea_pkg::KEY3_RST, xtea_pkg::KEY2_RST,
                              xtea_pkg::KEY1_RST, xtea_pkg::KEY0_RST};
            decrypt_shadow = 1'b0;
            n_sent  = 0;
            src_gap = 0;
            src_run = 0;
        end else begin
            next_valid = s_tvalid;
            next_we    = 1'b0;
            if (s_tvalid && s_tready) begin
                cipher_exp_q.push_back(xtea_crypt(t_word_pair'(s_tdata), key_shadow,
                                                  decrypt_shadow));
                n_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (cmd_q.size() > 0) begin
                    head = cmd_q[0];
                    if (head.kind == CMD_BLOCK) begin
                        next_valid = 1'b1;
                        s_tdata <= head.blk;
                        void'(cmd_q.pop_front());
                        src_gap = pick_gap(src_run);
                    end else if (n_recv >= n_sent) begin
                        if (head.kind == CMD_CFG) begin
                            next_we = 1'b1;
                            cfg_addr  <= head.addr;
                            cfg_wdata <= head.wdata;
                            apply_cfg(head.addr, head.wdata);
                        end
                        void'(cmd_q.pop_front());
                    end
                end
            end
            s_tvalid <= next_valid;
            cfg_we   <= next_we;
        end
    end

    // sink side: random stalls, in-order compare
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            n_recv   <= 0;
            sink_gap = 0;
            sink_run = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_word_pair'(m_tdata);
                if (cipher_exp_q.size() == 0) begin
                    $error("unexpected result transaction: %h", m_tdata);
                    n_err++;
                end else begin
                    want = cipher_exp_q.pop_front();
                    if (got.low !== want.low) begin
                        $error("result_low mismatch: expected %h, actual %h",
                               want.low, got.low);
                        n_err++;
                    end
                    if (got.high !== want.high) begin
                        $error("result_high mismatch: expected %h, actual %h",
                               want.high, got.high);
                        n_err++;
                    end
                end
                n_recv <= n_recv + 1;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_gap = pick_gap(sink_run);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int total, n_items;

        // default key, encipher
        add_block('0, '0);
        add_block('1, '1);
        add_block('0, '1);
        add_block('1, '0);
        add_block(32'h8000_0000, 32'h0000_0001);
        // mode write with upper bits set: only bit 0 counts
        add_cfg(xtea_pkg::REG_MODE, 32'hFFFF_FFFF);
        add_block('0, '0);
        add_block('1, '1);
        add_block('0, '1);
        add_block('1, '0);
        add_block(32'h0000_0001, 32'h8000_0000);
        // writes to unmapped indexes are dropped
        for (int a = REG_NONE_FIRST; a <= REG_NONE_LAST; a++)
            add_cfg(a[xtea_pkg::CFG_AW-1:0], '0);
        add_block(32'h0123_4567, 32'h89AB_CDEF);
        add_key('0, '0, '0, '0);
        add_block('0, '0);
        add_block('1, '1);
        add_block(32'hDEAD_BEEF, 32'h0BAD_F00D);
        add_cfg(xtea_pkg::REG_MODE, 32'hFFFF_FFFE);
        add_block('0, '0);
        add_block('1, '1);
        add_block(32'h0123_4567, 32'h89AB_CDEF);
        add_key('1, '1, '1, '1);
        add_block('0, '0);
        add_block('1, '1);
        add_cfg(xtea_pkg::REG_MODE, 32'h0000_0001);
        add_block('0, '0);
        add_block('1, '1);

        total = 0;
        while (total < RAND_ITEMS) begin
            add_key(rand_word(), rand_word(), rand_word(), rand_word());
            add_cfg(xtea_pkg::REG_MODE, $urandom);
            if ($urandom_range(0, 3) == 0)
                add_cfg(REG_CFG_SPARE(), $urandom);
            n_items = $urandom_range(60, 180);
            if (n_items > RAND_ITEMS - total)
                n_items = RAND_ITEMS - total;
            for (int i = 0; i < n_items; i++) begin
                add_block(rand_word(), rand_word());
                if ($urandom_range(0, 199) == 0)
                    add_drain();
            end
            add_drain();
            total += n_items;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (!(cmd_q.size() == 0 && !s_tvalid && n_recv >= n_sent))
            @(posedge clk);
        repeat (PIPE_LAT + 20) @(posedge clk);

        if (cipher_exp_q.size() != 0) begin
            $error("%0d expected results never arrived", cipher_exp_q.size());
            n_err++;
        end
        if (n_err == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    function automatic logic [xtea_pkg::CFG_AW-1:0] REG_CFG_SPARE();
        return xtea_pkg::CFG_AW'($urandom_range(REG_NONE_LAST, REG_NONE_FIRST));
    endfunction

endmodule
